[rtl/fsp_pkg.sv]
// shared constants and types of the fixed slab pool allocator
`default_nettype none
package fsp_pkg;

	localparam int MAX_SLABS_DEF  = 1024;
	localparam int ADDR_WIDTH_DEF = 64;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int SHIFT_W    = 5;
	localparam int TOTAL_W    = 11;
	localparam int COUNT_W    = 11;
	localparam int STATUS_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAB_SHIFT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLAB_TOTAL  = 2'd2;

	localparam logic [SHIFT_W-1:0] SLAB_SHIFT_RST = 5'd12;
	localparam logic [TOTAL_W-1:0] SLAB_TOTAL_RST = 11'd1024;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DOUBLE  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

	typedef struct packed {
		logic aligned;
		logic in_range;
	} dec_t;

endpackage
`default_nettype wire

[rtl/fixed_slab_pool_allocator_core.sv]
// top level of the fixed slab pool allocator: control, counters and result register
`default_nettype none
// Allocates and frees equal slabs of a region at region_base, slab i at
// region_base + (i << slab_shift). Allocate pops the most recently freed slab,
// else the lowest never-used one, else reports empty; free checks the address
// against the slab map. Each request passes through accept, decode with
// the synchronous read of the slab map and free stack memories, then the
// read-modify-write back, which waits while a held result is stalled. After
// reset a clearing pass zeroes the slab map; no item is accepted during it,
// configuration writes are taken. Results wait in an output register, so a new
// item can enter while a result is not yet taken.
module fixed_slab_pool_allocator_core #(
	parameter int MAX_SLABS  = fsp_pkg::MAX_SLABS_DEF,
	parameter int ADDR_WIDTH = fsp_pkg::ADDR_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [fsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           opcode,
	input  wire logic [ADDR_WIDTH-1:0]          address,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [fsp_pkg::STATUS_W-1:0]   status,
	output logic      [ADDR_WIDTH-1:0]          slab_address,
	output logic      [fsp_pkg::COUNT_W-1:0]    free_count,
	output logic      [fsp_pkg::COUNT_W-1:0]    used_count
);
	import fsp_pkg::*;

	localparam int IDX_W = $clog2(MAX_SLABS);
	localparam int CNT_W = $clog2(MAX_SLABS + 1);
	localparam int CW    = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_DEC, S_EXEC} state_t;

	state_t state_q;

	logic [ADDR_WIDTH-1:0] region_base_q;
	logic [SHIFT_W-1:0]    slab_shift_q;
	logic [TOTAL_W-1:0]    slab_total_q;

	logic [IDX_W-1:0] clr_q;
	logic [CW-1:0]    depth_q;
	logic [CW-1:0]    fresh_q;
	logic [CW-1:0]    alloc_q;

	logic                  op_q;
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [IDX_W-1:0]      slot_q;
	dec_t                  dec_q;

	logic [IDX_W-1:0] dec_slot;
	dec_t             dec_w;

	logic             used_we;
	logic [IDX_W-1:0] used_waddr;
	logic             used_wdata;
	logic [IDX_W-1:0] used_raddr;
	logic             used_rdata;

	logic             stk_we;
	logic [IDX_W-1:0] stk_waddr;
	logic [IDX_W-1:0] stk_raddr;
	logic [IDX_W-1:0] stk_rdata;

	logic                  in_acc;
	logic                  exec_go;
	logic [CW-1:0]         limit;
	logic [STATUS_W-1:0]   st_n;
	logic [IDX_W-1:0]      alloc_idx;
	logic                  alloc_got;
	logic                  from_stack;
	logic                  free_ok;
	logic [CW-1:0]         alloc_n;
	logic [CW-1:0]         free_n;
	logic [ADDR_WIDTH-1:0] res_addr;

	fsp_addr_decode #(
		.ADDR_WIDTH (ADDR_WIDTH),
		.MAX_SLABS  (MAX_SLABS)
	) u_decode (
		.address     (addr_q),
		.region_base (region_base_q),
		.slab_shift  (slab_shift_q),
		.slot        (dec_slot),
		.dec         (dec_w)
	);

	fsp_ram #(
		.WIDTH (1),
		.DEPTH (MAX_SLABS)
	) u_used_map (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.raddr (used_raddr),
		.rdata (used_rdata)
	);

	fsp_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_SLABS)
	) u_freed_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (slot_q),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign exec_go  = (state_q == S_EXEC) && (!out_valid || !out_stall);

	assign used_raddr = dec_slot;
	assign stk_raddr  = IDX_W'(depth_q - CW'(1));

	always_comb begin
		limit = (CW'(slab_total_q) > CW'(MAX_SLABS)) ? CW'(MAX_SLABS) : CW'(slab_total_q);

		from_stack = depth_q != '0;
		alloc_got  = from_stack || (fresh_q < limit);
		alloc_idx  = from_stack ? stk_rdata : fresh_q[IDX_W-1:0];
		free_ok    = dec_q.aligned && dec_q.in_range && used_rdata;

		st_n     = ST_OK;
		res_addr = '0;
		alloc_n  = alloc_q;
		if (op_q == OP_ALLOC) begin
			if (alloc_got) begin
				alloc_n  = alloc_q + CW'(1);
				res_addr = region_base_q + (ADDR_WIDTH'(alloc_idx) << slab_shift_q);
			end else begin
				st_n = ST_EMPTY;
			end
		end else begin
			if (free_ok) begin
				alloc_n = alloc_q - CW'(1);
			end else if (dec_q.aligned && dec_q.in_range && (CW'(slot_q) < limit)) begin
				st_n = ST_DOUBLE;
			end else begin
				st_n = ST_INVALID;
			end
		end
		free_n = (limit > alloc_n) ? (limit - alloc_n) : '0;

		used_we    = 1'b0;
		used_waddr = slot_q;
		used_wdata = 1'b0;
		stk_we     = 1'b0;
		stk_waddr  = depth_q[IDX_W-1:0];
		if (state_q == S_CLEAR) begin
			used_we    = 1'b1;
			used_waddr = clr_q;
		end else if (exec_go) begin
			if (op_q == OP_ALLOC) begin
				used_we    = alloc_got;
				used_waddr = alloc_idx;
				used_wdata = 1'b1;
			end else begin
				used_we = free_ok;
				stk_we  = free_ok;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= '0;
			slab_shift_q  <= SLAB_SHIFT_RST;
			slab_total_q  <= SLAB_TOTAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REGION_BASE: region_base_q <= cfg_wdata[ADDR_WIDTH-1:0];
				CFG_SLAB_SHIFT:  slab_shift_q  <= cfg_wdata[SHIFT_W-1:0];
				CFG_SLAB_TOTAL:  slab_total_q  <= cfg_wdata[TOTAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			depth_q   <= '0;
			fresh_q   <= '0;
			alloc_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (exec_go) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(MAX_SLABS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q   <= S_IDLE;
						alloc_q   <= alloc_n;
						if (op_q == OP_ALLOC) begin
							if (from_stack) begin
								depth_q <= depth_q - CW'(1);
							end else if (alloc_got) begin
								fresh_q <= fresh_q + CW'(1);
							end
						end else if (free_ok) begin
							depth_q <= depth_q + CW'(1);
						end
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= opcode;
			addr_q <= address;
		end
		if (state_q == S_DEC) begin
			slot_q <= dec_slot;
			dec_q  <= dec_w;
		end
		if (exec_go) begin
			status       <= st_n;
			slab_address <= res_addr;
			free_count   <= COUNT_W'(free_n);
			used_count   <= COUNT_W'(alloc_n);
		end
	end

endmodule
`default_nettype wire

[rtl/fsp_ram.sv]
// simple dual-port synchronous ram, one write port, one registered read port
`default_nettype none
module fsp_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/fsp_addr_decode.sv]
// turns a free address into a slab index and checks alignment and range
`default_nettype none
module fsp_addr_decode #(
	parameter int ADDR_WIDTH = 64,
	parameter int MAX_SLABS = 1024,
	localparam int IDX_W = $clog2(MAX_SLABS)
) (
	input  wire logic [ADDR_WIDTH-1:0]     address,
	input  wire logic [ADDR_WIDTH-1:0]     region_base,
	input  wire logic [fsp_pkg::SHIFT_W-1:0] slab_shift,
	output logic      [IDX_W-1:0]          slot,
	output fsp_pkg::dec_t                  dec
);
	import fsp_pkg::*;

	logic [ADDR_WIDTH-1:0] offset;
	logic [ADDR_WIDTH-1:0] low_mask;
	logic [ADDR_WIDTH-1:0] slot_full;

	always_comb begin
		offset       = address - region_base;
		low_mask     = (ADDR_WIDTH'(1) << slab_shift) - ADDR_WIDTH'(1);
		slot_full    = offset >> slab_shift;
		slot         = slot_full[IDX_W-1:0];
		dec.aligned  = (offset & low_mask) == '0;
		dec.in_range = ((slot_full >> IDX_W) == '0)
			&& ({1'b0, slot_full[IDX_W-1:0]} < (IDX_W+1)'(MAX_SLABS));
	end

endmodule
`default_nettype wire

[sim/fixed_slab_pool_allocator_core_tb.sv]
// self-checking testbench of the fixed slab pool allocator: directed table, random phases
`default_nettype none
module fixed_slab_pool_allocator_core_tb;
	import fsp_pkg::*;

	localparam int AW             = ADDR_WIDTH_DEF;
	localparam int NSLAB          = MAX_SLABS_DEF;
	localparam int PHASES         = 16;
	localparam int PRESSURE_PHASE = 2;
	localparam int HOLD_CYCLES    = 300;
	localparam int IDLE_LIMIT     = 5000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [AW-1:0]       slab_address;
		logic [COUNT_W-1:0]  free_count;
		logic [COUNT_W-1:0]  used_count;
	} slab_result_t;

	typedef struct packed {
		bit                 is_cfg;
		logic               op;
		logic [AW-1:0]      addr;
		bit                 typed;
		slab_result_t       res;
		logic [AW-1:0]      base;
		logic [SHIFT_W-1:0] shift;
		logic [TOTAL_W-1:0] total;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  opcode = OP_ALLOC;
	logic [AW-1:0]         address = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [AW-1:0]         slab_address;
	logic [COUNT_W-1:0]    free_count;
	logic [COUNT_W-1:0]    used_count;

	// tb-only tag riding along with the item: expectation typed in by hand
	bit                    row_typed = 1'b0;
	slab_result_t          typed_result = '0;

	// predictor copy of the configuration and pool state
	logic [AW-1:0]         cfg_base = '0;
	logic [SHIFT_W-1:0]    cfg_shift = SLAB_SHIFT_RST;
	logic [TOTAL_W-1:0]    cfg_total = SLAB_TOTAL_RST;
	bit [9:0]              freed_slabs [NSLAB];
	bit                    in_use [NSLAB];
	int unsigned           stk_depth = 0;
	int unsigned           fresh_idx = 0;
	int unsigned           out_total = 0;

	slab_result_t          pending_results [$];
	int                    mismatch_cnt = 0;
	int                    idle_cycles = 0;
	int                    burst_left = 0;
	int                    phase_num = -1;

	fixed_slab_pool_allocator_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.address     (address),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.slab_address(slab_address),
		.free_count  (free_count),
		.used_count  (used_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic slab_result_t pool_step(input logic op, input logic [AW-1:0] addr);
		slab_result_t  r;
		logic [AW-1:0] offset;
		logic [AW-1:0] low;
		logic [AW-1:0] slot;
		logic [AW-1:0] idx_w;
		int unsigned   limit;
		int unsigned   idx;
		r = '0;
		r.status = ST_OK;
		idx = 0;
		limit = (cfg_total > NSLAB) ? NSLAB : cfg_total;
		if (op == OP_ALLOC) begin
			if (stk_depth > 0) begin
				stk_depth--;
				idx = 32'(freed_slabs[stk_depth[9:0]]);
			end else if (fresh_idx < limit) begin
				idx = fresh_idx;
				fresh_idx++;
			end else begin
				r.status = ST_EMPTY;
			end
			if (r.status == ST_OK) begin
				in_use[idx[9:0]] = 1'b1;
				out_total++;
				idx_w = AW'(idx);
				r.slab_address = cfg_base + (idx_w << cfg_shift);
			end
		end else begin
			offset = addr - cfg_base;
			low = {{(AW-1){1'b0}}, 1'b1};
			low = (low << cfg_shift) - 1'b1;
			slot = offset >> cfg_shift;
			if ((offset & low) != '0 || slot >= NSLAB) begin
				r.status = ST_INVALID;
			end else begin
				idx = slot[31:0];
				if (in_use[idx[9:0]]) begin
					in_use[idx[9:0]] = 1'b0;
					freed_slabs[stk_depth[9:0]] = idx[9:0];
					stk_depth++;
					out_total--;
				end else if (idx < limit) begin
					r.status = ST_DOUBLE;
				end else begin
					r.status = ST_INVALID;
				end
			end
		end
		r.free_count = (limit > out_total) ? COUNT_W'(limit - out_total) : '0;
		r.used_count = COUNT_W'(out_total);
		return r;
	endfunction

	function automatic plan_row_t item_row(input logic op, input logic [AW-1:0] addr);
		plan_row_t r;
		r = '0;
		r.op = op;
		r.addr = addr;
		return r;
	endfunction

	function automatic plan_row_t typed_row(input logic op, input logic [AW-1:0] addr,
			input logic [STATUS_W-1:0] st, input logic [AW-1:0] sa, input int fc, input int uc);
		plan_row_t r;
		r = item_row(op, addr);
		r.typed = 1'b1;
		r.res.status = st;
		r.res.slab_address = sa;
		r.res.free_count = COUNT_W'(fc);
		r.res.used_count = COUNT_W'(uc);
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic [AW-1:0] base,
			input logic [SHIFT_W-1:0] shift, input logic [TOTAL_W-1:0] total);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.base = base;
		r.shift = shift;
		r.total = total;
		return r;
	endfunction

	task automatic push_item(input logic op, input logic [AW-1:0] addr, input bit typed,
			input slab_result_t res);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		opcode <= op;
		address <= addr;
		row_typed <= typed;
		typed_result <= res;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		burst_left--;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_set(input logic [AW-1:0] base, input logic [SHIFT_W-1:0] shift,
			input logic [TOTAL_W-1:0] total);
		cfg_we <= 1'b1;
		cfg_index <= CFG_REGION_BASE;
		cfg_wdata <= CFG_DATA_W'(base);
		@(posedge clk);
		cfg_base = base;
		cfg_index <= CFG_SLAB_SHIFT;
		cfg_wdata <= CFG_DATA_W'(shift);
		@(posedge clk);
		cfg_shift = shift;
		cfg_index <= CFG_SLAB_TOTAL;
		cfg_wdata <= CFG_DATA_W'(total);
		@(posedge clk);
		cfg_total = total;
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : monitor
		slab_result_t got;
		slab_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.status = status;
				got.slab_address = slab_address;
				got.free_count = free_count;
				got.used_count = used_count;
				if (pending_results.size() == 0) begin
					$display("%0t: result with no item pending: status %0d addr %h free %0d used %0d",
						$time, got.status, got.slab_address, got.free_count, got.used_count);
					mismatch_cnt++;
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						$display("%0t: expected status %0d addr %h free %0d used %0d, got status %0d addr %h free %0d used %0d",
							$time, want.status, want.slab_address, want.free_count,
							want.used_count, got.status, got.slab_address, got.free_count,
							got.used_count);
						mismatch_cnt++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = pool_step(opcode, address);
				if (row_typed)
					want = typed_result;
				pending_results.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("fixed_slab_pool_allocator_core_tb failed");
			$finish;
		end
	end

	initial begin : receiver
		int  mode;
		int  len;
		bit  held;
		held = 1'b0;
		@(posedge clk);
		forever begin
			if (!held && phase_num == PRESSURE_PHASE) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			len = $urandom_range(10, 120);
			repeat (len) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					2: out_stall <= ($urandom_range(0, 99) < 75);
					default: out_stall <= ~out_stall;
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		plan_row_t          plan [$];
		int                 n_items;
		int                 alloc_pct;
		int                 hi;
		int                 limit;
		int                 sel;
		int unsigned        idx;
		logic               op;
		logic [AW-1:0]      a;
		logic [AW-1:0]      b;
		logic [AW-1:0]      low;
		logic [AW-1:0]      idx_w;
		logic [SHIFT_W-1:0] sh;
		logic [TOTAL_W-1:0] tot;

		// reset configuration first
		plan.push_back(typed_row(OP_ALLOC, '1, ST_OK, '0, 1023, 1));
		plan.push_back(typed_row(OP_FREE, '0, ST_OK, '0, 1024, 0));
		plan.push_back(cfg_row(64'h1_0000, 5'd4, 11'd2));
		plan.push_back(typed_row(OP_ALLOC, '0, ST_OK, 64'h1_0000, 1, 1));
		plan.push_back(typed_row(OP_ALLOC, '0, ST_OK, 64'h1_0010, 0, 2));
		plan.push_back(typed_row(OP_ALLOC, '0, ST_EMPTY, '0, 0, 2));
		plan.push_back(typed_row(OP_FREE, 64'h1_0010, ST_OK, '0, 1, 1));
		plan.push_back(typed_row(OP_FREE, 64'h1_0010, ST_DOUBLE, '0, 1, 1));
		plan.push_back(typed_row(OP_FREE, 64'h1_0008, ST_INVALID, '0, 1, 1));
		plan.push_back(typed_row(OP_FREE, '0, ST_INVALID, '0, 1, 1));
		plan.push_back(typed_row(OP_FREE, 64'h1_0020, ST_INVALID, '0, 1, 1));
		plan.push_back(typed_row(OP_FREE, '1, ST_INVALID, '0, 1, 1));
		plan.push_back(typed_row(OP_ALLOC, '0, ST_OK, 64'h1_0010, 0, 2));
		plan.push_back(typed_row(OP_FREE, 64'h1_0000, ST_OK, '0, 1, 1));
		plan.push_back(typed_row(OP_FREE, 64'h1_0010, ST_OK, '0, 2, 0));
		plan.push_back(typed_row(OP_ALLOC, '0, ST_OK, 64'h1_0010, 1, 1));
		plan.push_back(typed_row(OP_ALLOC, '0, ST_OK, 64'h1_0000, 0, 2));
		plan.push_back(typed_row(OP_FREE, 64'h1_0010, ST_OK, '0, 1, 1));
		// slab count lowered to zero while slabs are out
		plan.push_back(cfg_row(64'h1_0000, 5'd4, 11'd0));
		plan.push_back(typed_row(OP_FREE, 64'h1_0000, ST_OK, '0, 0, 0));
		plan.push_back(typed_row(OP_ALLOC, '0, ST_OK, 64'h1_0000, 0, 1));
		plan.push_back(typed_row(OP_ALLOC, '0, ST_OK, 64'h1_0010, 0, 2));
		plan.push_back(typed_row(OP_ALLOC, '0, ST_EMPTY, '0, 0, 2));
		plan.push_back(typed_row(OP_FREE, 64'h1_0020, ST_INVALID, '0, 0, 2));
		plan.push_back(cfg_row('1, 5'd31, 11'd2047));
		plan.push_back(item_row(OP_ALLOC, 64'h5555_5555_5555_5555));
		plan.push_back(item_row(OP_FREE, 64'h0000_0000_FFFF_FFFF));
		plan.push_back(cfg_row(64'h8000_0000_0000_0000, 5'd0, 11'd1024));
		plan.push_back(item_row(OP_ALLOC, 64'hAAAA_AAAA_AAAA_AAAA));
		plan.push_back(item_row(OP_FREE, 64'h8000_0000_0000_03FF));
		plan.push_back(item_row(OP_FREE, 64'h8000_0000_0000_0400));
		plan.push_back(item_row(OP_FREE, 64'h8000_0000_0000_0000));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				cfg_set(plan[i].base, plan[i].shift, plan[i].total);
			end else begin
				push_item(plan[i].op, plan[i].addr, plan[i].typed, plan[i].res);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			sel = $urandom_range(0, 4);
			b = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
			sel = $urandom_range(0, 5);
			sh = (sel == 0) ? 5'd0 : (sel == 1) ? 5'd31 : (sel == 2) ? 5'd30 :
				SHIFT_W'($urandom_range(0, 31));
			sel = $urandom_range(0, 11);
			case (sel)
				0: tot = 11'd0;
				1: tot = 11'd1;
				2: tot = 11'd1024;
				3: tot = 11'd2047;
				4: tot = 11'd1023;
				5: tot = TOTAL_W'($urandom_range(1025, 2047));
				default: tot = TOTAL_W'($urandom_range(1, 48));
			endcase
			cfg_set(b, sh, tot);
			phase_num = p;
			limit = (cfg_total > NSLAB) ? NSLAB : cfg_total;
			hi = ((limit > fresh_idx) ? limit : fresh_idx) + 3;
			if (hi > NSLAB - 1)
				hi = NSLAB - 1;
			low = {{(AW-1){1'b0}}, 1'b1};
			low = (low << cfg_shift) - 1'b1;
			alloc_pct = $urandom_range(25, 75);
			n_items = $urandom_range(60, 140);
			repeat (n_items) begin
				idx = $urandom_range(0, hi);
				idx_w = AW'(idx);
				a = cfg_base + (idx_w << cfg_shift);
				sel = $urandom_range(0, 9);
				if ($urandom_range(0, 99) < alloc_pct) begin
					op = OP_ALLOC;
					a = {$urandom, $urandom};
				end else begin
					op = OP_FREE;
					if (sel == 0) begin
						a = {$urandom, $urandom};
					end else if (sel == 1 && cfg_shift != '0) begin
						idx_w = {$urandom, $urandom} & low;
						if (idx_w == '0)
							idx_w = AW'(1);
						a = a + idx_w;
					end
				end
				push_item(op, a, 1'b0, '0);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("fixed_slab_pool_allocator_core_tb passed");
		else
			$display("fixed_slab_pool_allocator_core_tb failed");
		$finish;
	end

endmodule
`default_nettype wire
